@@ rtl/sil_pkg.sv @@
// Shared types and constants for the sorted insert list unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package sil_pkg;

  localparam int VALUE_W   = 32;
  localparam int POS_W     = 5;
  localparam int M_TDATA_W = 40;

  // Flipping the sign bit turns signed order into unsigned order.
  localparam logic [VALUE_W-1:0] SIGN_FLIP = 32'h8000_0000;

  // One queued insert request, value held as an order-preserving key.
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] key;
  } q_item_t;

endpackage
`default_nettype wire

@@ rtl/sil_front.sv @@
// Front end of the sorted insert list unit: input handshake and a two-entry
// queue of insert requests, stored as sign-flipped keys. Uses sil_pkg.
`default_nettype none
module sil_front (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire [sil_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] value
  output sil_pkg::q_item_t             q_head,
  input  wire                          q_pop
);
  import sil_pkg::*;

  logic [VALUE_W-1:0] slot [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         fill;
  logic               push;
  logic               pop;

  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign pop      = q_pop && (fill != 2'd0);

  assign q_head.valid = (fill != 2'd0);
  assign q_head.key   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= s_tdata ^ SIGN_FLIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/sil_back.sv @@
// Back end of the sorted insert list unit: list memory and the pass that
// inserts one key while streaming the list out. Uses sil_pkg.
`default_nettype none
module sil_back #(
  parameter int CAPACITY = 32
) (
  input  wire                              clk,
  input  wire                              rst,
  input  sil_pkg::q_item_t                 q_head,
  output logic                             q_pop,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [sil_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                             m_tlast,
  output logic                             m_tuser
);
  import sil_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic               state;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      count;
  logic               drop;
  logic               inserted;
  logic [VALUE_W-1:0] key;
  logic [VALUE_W-1:0] carry;

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rd_data;
  logic [AW-1:0]      rd_addr;

  logic               out_valid;
  logic [VALUE_W-1:0] out_entry;
  logic [POS_W-1:0]   out_pos;
  logic               out_last;
  logic               out_drop;

  logic               advance;
  logic               tail;
  logic               take;
  logic               run_last;
  logic [VALUE_W-1:0] emit;
  logic [CW-1:0]      idx_inc;
  logic [CW+POS_W-1:0] pos_ext;

  assign advance  = (state == ST_RUN) && (!out_valid || m_tready);
  assign tail     = !drop && (idx == count);
  // Insert point: first stored key that is not below the new one.
  assign take     = inserted || tail || !(key > rd_data);
  assign emit     = (drop || !take) ? rd_data : carry;
  assign run_last = drop ? (idx == count - CW'(1)) : tail;
  assign idx_inc  = idx + CW'(1);
  assign pos_ext  = {{POS_W{1'b0}}, idx};
  assign q_pop    = (state == ST_IDLE) && q_head.valid;

  always_comb begin
    if (state == ST_IDLE) begin
      rd_addr = '0;
    end else if (advance) begin
      rd_addr = idx_inc[AW-1:0];
    end else begin
      rd_addr = idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !drop) begin
      mem[idx[AW-1:0]] <= emit;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_head.valid) begin
            state <= ST_RUN;
            idx   <= '0;
          end
        end
        ST_RUN: begin
          if (advance) begin
            out_valid <= 1'b1;
            if (run_last) begin
              state <= ST_IDLE;
              if (!drop) begin
                count <= count + CW'(1);
              end
            end else begin
              idx <= idx_inc;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Per-run payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      key      <= q_head.key;
      carry    <= q_head.key;
      inserted <= 1'b0;
      drop     <= (count == CW'(CAPACITY));
    end else if (advance && !drop) begin
      carry    <= take ? rd_data : carry;
      inserted <= inserted || take;
    end
    if (advance) begin
      out_entry <= emit ^ SIGN_FLIP;
      out_pos   <= pos_ext[POS_W-1:0];
      out_last  <= run_last;
      out_drop  <= drop;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_TDATA_W - VALUE_W - POS_W){1'b0}}, out_pos, out_entry};
  assign m_tlast  = out_last;
  assign m_tuser  = out_drop;

endmodule
`default_nettype wire

@@ rtl/sorted_insert_list_unit.sv @@
// Top level of the sorted insert list unit: front queue plus list engine.
// Depends on sil_pkg, sil_front and sil_back.
//
// Keeps an ascending list of signed 32-bit values, up to CAPACITY entries.
// Every accepted value is inserted ahead of the first entry greater than or
// equal to it, then the whole list streams out on the master side, one
// transfer per entry with its position, tlast on the final one. When the
// list is already full the value is discarded and the unchanged list is
// sent with tuser set on every transfer. The engine makes one pass over the
// list memory per input, one entry per cycle while the output is not stalled
// (one read and one write port), plus a pass through the idle state to take
// the next value from the queue. A two-entry queue in front takes new values
// while a run is in progress.
`default_nettype none
module sorted_insert_list_unit #(
  parameter int CAPACITY = 32
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_tvalid,
  output logic                           s_tready,
  input  wire [sil_pkg::VALUE_W-1:0]     s_tdata,   // [31:0] value
  output logic                           m_tvalid,
  input  wire                            m_tready,
  output logic [sil_pkg::M_TDATA_W-1:0]  m_tdata,   // [31:0] entry, [36:32] position
  output logic                           m_tlast,
  output logic                           m_tuser    // [0] dropped
);
  import sil_pkg::*;

  q_item_t q_head;
  logic    q_pop;

  sil_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  sil_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

@@ tb/tb_sorted_insert_list_unit.sv @@
// Self-checking testbench for sorted_insert_list_unit: a directed table, then random values.
// A local sorted-list predictor queues the expected run for every accepted value.
// Depends on sil_pkg and the RTL of sorted_insert_list_unit.
module tb_sorted_insert_list_unit;
  import sil_pkg::*;

  localparam int CAP        = 32;
  localparam int RAND_ITEMS = 236;
  localparam int WDOG_LIMIT = 4000;
  localparam int TAIL_WAIT  = 2 * CAP + 8;
  localparam int MAX_SHOWN  = 10;

  localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  typedef struct {
    logic [VALUE_W-1:0] entry;
    logic [POS_W-1:0]   position;
    logic               last;
    logic               dropped;
  } list_beat_t;

  // One directed row: value sent reps times (random values when reps > 1).
  // When typed is set, list length, drop flag and head are checked after the row.
  typedef struct {
    logic [VALUE_W-1:0] value;
    int                 reps;
    bit                 typed;
    int                 exp_len;
    bit                 exp_drop;
    logic [VALUE_W-1:0] exp_head;
  } stim_row_t;

  localparam int N_ROWS   = 15;
  localparam int N_SINGLE = 12;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [VALUE_W-1:0]    s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tlast;
  logic                  m_tuser;

  // predictor state
  logic signed [VALUE_W-1:0] sorted_vals [CAP];
  int                        list_len = 0;
  bit                        last_drop = 1'b0;
  list_beat_t                pending_entries [$];

  int  mismatch_count = 0;
  int  stall_cycles = 0;
  bit  no_idle = 1'b0;

  stim_row_t dir_rows [N_ROWS];

  sorted_insert_list_unit #(.CAPACITY(CAP)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] exp_v,
                                 input logic [VALUE_W-1:0] act_v);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN)
      $display("MISMATCH %s: expected %h, got %h", what, exp_v, act_v);
  endtask

  // Insert ahead of the first entry >= v (or drop when full), then queue the whole list.
  function automatic void insert_value(input logic signed [VALUE_W-1:0] v);
    int pos;
    int k;
    list_beat_t b;
    pos = 0;
    if (list_len >= CAP) begin
      last_drop = 1'b1;
    end else begin
      last_drop = 1'b0;
      while (pos < list_len && v > sorted_vals[pos])
        pos++;
      for (k = list_len; k > pos; k--)
        sorted_vals[k] = sorted_vals[k-1];
      sorted_vals[pos] = v;
      list_len++;
    end
    for (k = 0; k < list_len; k++) begin
      b.entry    = sorted_vals[k];
      b.position = k[POS_W-1:0];
      b.last     = (k == list_len - 1);
      b.dropped  = last_drop;
      pending_entries.push_back(b);
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while (!no_idle && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    insert_value(v);
    @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(9))
      0:       v = VAL_MIN;
      1:       v = VAL_MAX;
      2:       v = $urandom_range(6) - 3;
      3, 4:    v = (list_len > 0) ? sorted_vals[$urandom_range(list_len - 1)] : $urandom;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // receiver backpressure
  always @(negedge clk) begin
    m_tready <= no_idle || ($urandom_range(99) >= 15);
  end

  // output checker
  always @(posedge clk) begin
    list_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_entries.size() == 0) begin
        report_mismatch("transfer with nothing pending", '0, m_tdata[VALUE_W-1:0]);
      end else begin
        want = pending_entries.pop_front();
        if (m_tdata[VALUE_W-1:0] !== want.entry)
          report_mismatch("entry", want.entry, m_tdata[VALUE_W-1:0]);
        if (m_tdata[VALUE_W +: POS_W] !== want.position)
          report_mismatch("position", VALUE_W'(want.position),
                          VALUE_W'(m_tdata[VALUE_W +: POS_W]));
        if (m_tlast !== want.last)
          report_mismatch("last", VALUE_W'(want.last), VALUE_W'(m_tlast));
        if (m_tuser !== want.dropped)
          report_mismatch("dropped", VALUE_W'(want.dropped), VALUE_W'(m_tuser));
      end
    end
  end

  // watchdog: cycles without a transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    dir_rows = '{
      '{32'h0000_0000, 1, 1'b1, 1, 1'b0, 32'h0000_0000},  // first value after reset
      '{VAL_MIN,       1, 1'b1, 2, 1'b0, VAL_MIN},
      '{VAL_MAX,       1, 1'b1, 3, 1'b0, VAL_MIN},
      '{32'hFFFF_FFFF, 1, 1'b0, 0, 1'b0, '0},
      '{32'h0000_0001, 1, 1'b0, 0, 1'b0, '0},
      '{VAL_MIN,       1, 1'b1, 6, 1'b0, VAL_MIN},        // equal to head
      '{VAL_MAX,       1, 1'b0, 0, 1'b0, '0},              // equal to tail
      '{32'h0000_0000, 1, 1'b0, 0, 1'b0, '0},              // equal in the middle
      '{32'h8000_0001, 1, 1'b0, 0, 1'b0, '0},
      '{32'h7FFF_FFFE, 1, 1'b0, 0, 1'b0, '0},
      '{32'h5555_5555, 1, 1'b0, 0, 1'b0, '0},
      '{32'hAAAA_AAAA, 1, 1'b0, 0, 1'b0, '0},
      '{32'h0000_0000, CAP - N_SINGLE, 1'b1, CAP, 1'b0, VAL_MIN},  // fill to capacity
      '{VAL_MIN,       1, 1'b1, CAP, 1'b1, VAL_MIN},      // full: dropped
      '{VAL_MAX,       1, 1'b1, CAP, 1'b1, VAL_MIN}
    };

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].reps == 1) begin
        send_value(dir_rows[r].value);
      end else begin
        for (int n = 0; n < dir_rows[r].reps; n++)
          send_value($urandom);
      end
      if (dir_rows[r].typed) begin
        if (list_len != dir_rows[r].exp_len)
          report_mismatch("list length", dir_rows[r].exp_len, list_len);
        if (last_drop != dir_rows[r].exp_drop)
          report_mismatch("drop flag", VALUE_W'(dir_rows[r].exp_drop), VALUE_W'(last_drop));
        if (sorted_vals[0] !== dir_rows[r].exp_head)
          report_mismatch("list head", dir_rows[r].exp_head, sorted_vals[0]);
      end
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      no_idle = (i >= 100 && i < 180);
      // hold off until the previous runs have fully drained
      if (i == 40 || i == 200) begin
        s_tvalid <= 1'b0;
        wait (pending_entries.size() == 0);
        @(negedge clk);
      end
      send_value(pick_value());
    end
    s_tvalid <= 1'b0;
    no_idle = 1'b0;

    wait (pending_entries.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk);
    if (pending_entries.size() != 0)
      report_mismatch("results left over", '0, pending_entries.size());

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
